/* rtl/ivgr_pkg.sv */
// ----------------------------------------------------------------------------
// Image vector and GOT relocator package
// Shared types and constants for the relocator and its layout checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ivgr_pkg;

  localparam logic [31:0] ERASED_MARK = 32'hF108F85F;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_VECTOR = 2'd1,
    CMD_GOT    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RGN_NONE   = 2'd0,
    RGN_VECTOR = 2'd1,
    RGN_GOT    = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LAYOUT  = 3'd1,
    ST_HANDLER = 3'd2,
    ST_BEYOND  = 3'd3,
    ST_FAILED  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    REG_LOAD_BASE    = 3'd0,
    REG_IMAGE_BYTES  = 3'd1,
    REG_VECTOR_COUNT = 3'd2,
    REG_TABLE_OFFSET = 3'd3,
    REG_TABLE_BYTES  = 3'd4,
    REG_VECTOR_ROOM  = 3'd5,
    REG_TABLE_ROOM   = 3'd6
  } reg_e;

  typedef struct packed {
    logic [31:0] load_base;
    logic [31:0] image_bytes;
    logic [8:0]  vector_count;
    logic [31:0] table_offset;
    logic [31:0] table_bytes;
    logic [8:0]  vector_room;
    logic [10:0] table_room;
  } cfg_t;

  typedef struct packed {
    logic [31:0] relocated;
    region_e     region;
    logic [9:0]  position;
    status_e     status;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/ivgr_layout_chk.sv */
// ----------------------------------------------------------------------------
// Image layout checker
// Checks the configured image layout against size, alignment and capacity
// rules and gives the verdict for a start transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ivgr_layout_chk
  import ivgr_pkg::*;
#(
  parameter int unsigned MAX_VECTORS     = 256,
  parameter int unsigned MAX_TABLE_WORDS = 1024
) (
  input  wire cfg_t cfg_i,
  output logic      layout_ok_o
);

  logic [31:0] vc_ext;
  logic [31:0] table_words;
  logic [31:0] room_left;
  logic        reject;

  always_comb begin
    vc_ext      = {23'd0, cfg_i.vector_count};
    table_words = {2'd0, cfg_i.table_bytes[31:2]};
    room_left   = cfg_i.image_bytes - cfg_i.table_offset;
    reject      = (cfg_i.image_bytes < 32'd8)
               || (cfg_i.vector_count < 9'd2)
               || (cfg_i.vector_count > cfg_i.vector_room)
               || (vc_ext > 32'(MAX_VECTORS))
               || (vc_ext > {2'd0, cfg_i.image_bytes[31:2]})
               || (cfg_i.table_offset[1:0] != 2'd0)
               || (cfg_i.table_bytes[1:0] != 2'd0)
               || (cfg_i.table_offset > cfg_i.image_bytes)
               || (cfg_i.table_bytes > room_left)
               || (table_words > {21'd0, cfg_i.table_room})
               || (table_words > 32'(MAX_TABLE_WORDS));
    layout_ok_o = !reject;
  end

endmodule

`default_nettype wire

/* rtl/image_vector_got_relocator.sv */
// ----------------------------------------------------------------------------
// Image vector and GOT relocator
// Relocates vector table and GOT words of a position-independent image as
// they stream through, after a start transaction has checked the layout.
//
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   command_i, word_i
// out       output     out_valid_o / out_ready_i relocated_o, region_o,
//                                                position_o, status_o, last_o
// cfg       input      cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// Every transaction passes from acceptance into the input register, then
// through the relocation logic into the result register.
// A new transaction is accepted in every cycle while results are taken.
// The layout check works directly on the configuration registers, so a start
// may follow a register write at once. Reset leaves the job failed until a
// start passes. A stalled result holds the input register, which then stalls
// the input.
// ----------------------------------------------------------------------------
`default_nettype none

module image_vector_got_relocator
  import ivgr_pkg::*;
#(
  parameter int unsigned MAX_VECTORS     = 256,
  parameter int unsigned MAX_TABLE_WORDS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] word_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      relocated_o,
  output logic [1:0]       region_o,
  output logic [9:0]       position_o,
  output logic [2:0]       status_o,
  output logic             last_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i
);

  cfg_t        cfg_q;
  logic        layout_ok;

  logic        s1_valid_q;
  logic [1:0]  cmd_q;
  logic [31:0] word_q;
  logic        adv;

  logic [8:0]  vector_pos_q, vector_pos_d;
  logic [29:0] table_pos_q, table_pos_d;
  logic        failed_q, failed_d;
  logic [29:0] table_words;

  logic        out_valid_q;
  res_t        res_q, res_d;

  ivgr_layout_chk #(
    .MAX_VECTORS     (MAX_VECTORS),
    .MAX_TABLE_WORDS (MAX_TABLE_WORDS)
  ) u_layout_chk (
    .cfg_i       (cfg_q),
    .layout_ok_o (layout_ok)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LOAD_BASE:    cfg_q.load_base    <= cfg_wdata_i;
        REG_IMAGE_BYTES:  cfg_q.image_bytes  <= cfg_wdata_i;
        REG_VECTOR_COUNT: cfg_q.vector_count <= cfg_wdata_i[8:0];
        REG_TABLE_OFFSET: cfg_q.table_offset <= cfg_wdata_i;
        REG_TABLE_BYTES:  cfg_q.table_bytes  <= cfg_wdata_i;
        REG_VECTOR_ROOM:  cfg_q.vector_room  <= cfg_wdata_i[8:0];
        REG_TABLE_ROOM:   cfg_q.table_room   <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  assign adv         = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || adv;
  assign table_words = cfg_q.table_bytes[31:2];

  always_comb begin
    res_d        = '0;
    res_d.region = RGN_NONE;
    res_d.status = ST_OK;
    vector_pos_d = vector_pos_q;
    table_pos_d  = table_pos_q;
    failed_d     = failed_q;
    unique case (cmd_q)
      CMD_START: begin
        if (layout_ok) begin
          failed_d     = 1'b0;
          vector_pos_d = '0;
          table_pos_d  = '0;
        end else begin
          failed_d     = 1'b1;
          res_d.status = ST_LAYOUT;
        end
      end
      CMD_VECTOR: begin
        if (failed_q) begin
          res_d.status = ST_FAILED;
        end else if (vector_pos_q >= cfg_q.vector_count) begin
          res_d.status = ST_BEYOND;
        end else begin
          vector_pos_d = vector_pos_q + 9'd1;
          priority if (vector_pos_q == 9'd0) begin
            res_d.relocated = word_q;
            res_d.region    = RGN_VECTOR;
          end else if (word_q == 32'd0 || word_q == ERASED_MARK) begin
            res_d.region    = RGN_VECTOR;
            res_d.position  = {1'b0, vector_pos_q};
          end else if (!word_q[0] || ({word_q[31:1], 1'b0} >= cfg_q.image_bytes)) begin
            vector_pos_d    = vector_pos_q;
            failed_d        = 1'b1;
            res_d.status    = ST_HANDLER;
          end else begin
            res_d.relocated = cfg_q.load_base + word_q;
            res_d.region    = RGN_VECTOR;
            res_d.position  = {1'b0, vector_pos_q};
          end
          if (res_d.region == RGN_VECTOR) begin
            res_d.last = (vector_pos_d >= cfg_q.vector_count) &&
                         (table_pos_q >= table_words);
          end
        end
      end
      CMD_GOT: begin
        if (failed_q) begin
          res_d.status = ST_FAILED;
        end else if (table_pos_q >= table_words) begin
          res_d.status = ST_BEYOND;
        end else begin
          table_pos_d     = table_pos_q + 30'd1;
          res_d.relocated = (word_q < cfg_q.image_bytes) ? cfg_q.load_base + word_q : word_q;
          res_d.region    = RGN_GOT;
          res_d.position  = table_pos_q[9:0];
          res_d.last      = (vector_pos_q >= cfg_q.vector_count) && (table_pos_d >= table_words);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      vector_pos_q <= '0;
      table_pos_q  <= '0;
      failed_q     <= 1'b1;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q  <= 1'b1;
        vector_pos_q <= vector_pos_d;
        table_pos_q  <= table_pos_d;
        failed_q     <= failed_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q  <= command_i;
      word_q <= word_i;
    end
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign relocated_o = res_q.relocated;
  assign region_o    = res_q.region;
  assign position_o  = res_q.position;
  assign status_o    = res_q.status;
  assign last_o      = res_q.last;

  a_region_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && region_o != RGN_NONE |-> status_o == ST_OK)
    else $error("Relocated word carries a non-ok status.");

  a_last_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> region_o != RGN_NONE)
    else $error("Last flag set on a transaction that writes nothing.");

  a_handler_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_d.status == ST_HANDLER |=> failed_q)
    else $error("Bad handler did not set the failed flag.");

  a_vector_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && res_d.region == RGN_VECTOR |=> vector_pos_q == $past(vector_pos_q) + 9'd1)
    else $error("Vector index did not advance on a vector word.");

endmodule

`default_nettype wire

/* dv/relocation_checker.sv */
// ----------------------------------------------------------------------------
// Relocation checker
// Watches the input, result and register write ports of the image vector and
// GOT relocator. It predicts every result from its own copy of the layout
// registers and job state, and compares each result transaction, field by
// field, with the oldest prediction.
// ----------------------------------------------------------------------------
module relocation_checker
  import ivgr_pkg::*;
#(
  parameter int unsigned MAX_VECTORS     = 256,
  parameter int unsigned MAX_TABLE_WORDS = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] word_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] relocated_i,
  input  wire logic [1:0]  region_i,
  input  wire logic [9:0]  position_i,
  input  wire logic [2:0]  status_i,
  input  wire logic        last_i,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  output int               pending_o,
  output int               fail_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        layout;
  logic [8:0]  vec_idx;
  logic [29:0] got_idx;
  logic        job_failed;
  res_t        expected_words[$];
  int          fail_count;

  function automatic logic layout_passes();
    logic [31:0] table_words;
    table_words = layout.table_bytes >> 2;
    if (layout.image_bytes < 32'd8) return 1'b0;
    if (layout.vector_count < 9'd2) return 1'b0;
    if (layout.vector_count > layout.vector_room) return 1'b0;
    if (32'(layout.vector_count) > MAX_VECTORS) return 1'b0;
    if (32'(layout.vector_count) > (layout.image_bytes >> 2)) return 1'b0;
    if (layout.table_offset[1:0] != 2'b00 || layout.table_bytes[1:0] != 2'b00) return 1'b0;
    if (layout.table_offset > layout.image_bytes) return 1'b0;
    if (layout.table_bytes > layout.image_bytes - layout.table_offset) return 1'b0;
    if (table_words > 32'(layout.table_room)) return 1'b0;
    if (table_words > MAX_TABLE_WORDS) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic regions_complete();
    return 32'(vec_idx) >= 32'(layout.vector_count) &&
           32'(got_idx) >= (layout.table_bytes >> 2);
  endfunction

  function automatic res_t relocate_word(input logic [1:0] cmd, input logic [31:0] w);
    res_t r;
    r = '0;
    case (cmd)
      CMD_START: begin
        if (layout_passes()) begin
          job_failed = 1'b0;
          vec_idx    = '0;
          got_idx    = '0;
        end else begin
          job_failed = 1'b1;
          r.status   = ST_LAYOUT;
        end
      end
      CMD_VECTOR: begin
        if (job_failed) begin
          r.status = ST_FAILED;
        end else if (vec_idx >= layout.vector_count) begin
          r.status = ST_BEYOND;
        end else if (vec_idx == '0) begin
          r.relocated = w;
          r.region    = RGN_VECTOR;
        end else if (w == '0 || w == ERASED_MARK) begin
          r.region   = RGN_VECTOR;
          r.position = 10'(vec_idx);
        end else if (!w[0] || {w[31:1], 1'b0} >= layout.image_bytes) begin
          job_failed = 1'b1;
          r.status   = ST_HANDLER;
        end else begin
          r.relocated = layout.load_base + w;
          r.region    = RGN_VECTOR;
          r.position  = 10'(vec_idx);
        end
        if (r.region == RGN_VECTOR) begin
          vec_idx = vec_idx + 9'd1;
          r.last  = regions_complete();
        end
      end
      CMD_GOT: begin
        if (job_failed) begin
          r.status = ST_FAILED;
        end else if (32'(got_idx) >= (layout.table_bytes >> 2)) begin
          r.status = ST_BEYOND;
        end else begin
          r.relocated = (w < layout.image_bytes) ? layout.load_base + w : w;
          r.region    = RGN_GOT;
          r.position  = got_idx[9:0];
          got_idx     = got_idx + 30'd1;
          r.last      = regions_complete();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      layout     = '0;
      vec_idx    = '0;
      got_idx    = '0;
      job_failed = 1'b1;
      fail_count = 0;
      expected_words.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t ns: unexpected result: %h region %0d pos %0d status %0d last %0d",
                     $time, relocated_i, region_i, position_i, status_i, last_i);
          end
        end else begin
          want = expected_words.pop_front();
          if (relocated_i !== want.relocated || region_i !== want.region ||
              position_i !== want.position || status_i !== want.status ||
              last_i !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t ns: expected %h region %0d pos %0d status %0d last %0d",
                       $time, want.relocated, want.region, want.position, want.status,
                       want.last);
              $display("%0t ns: actual   %h region %0d pos %0d status %0d last %0d",
                       $time, relocated_i, region_i, position_i, status_i, last_i);
            end
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LOAD_BASE:    layout.load_base    = cfg_wdata_i;
          REG_IMAGE_BYTES:  layout.image_bytes  = cfg_wdata_i;
          REG_VECTOR_COUNT: layout.vector_count = cfg_wdata_i[8:0];
          REG_TABLE_OFFSET: layout.table_offset = cfg_wdata_i;
          REG_TABLE_BYTES:  layout.table_bytes  = cfg_wdata_i;
          REG_VECTOR_ROOM:  layout.vector_room  = cfg_wdata_i[8:0];
          REG_TABLE_ROOM:   layout.table_room   = cfg_wdata_i[10:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_words.push_back(relocate_word(command_i, word_i));
      end
      pending_o    <= expected_words.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// Image vector and GOT relocator testbench
// Drives layout register writes and streams of start, vector and GOT word
// transactions with random idle cycles on both channels. A short directed
// sequence covers the special cases, then random relocation jobs with mostly
// well-formed layouts follow. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

  import ivgr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned ITEM_TARGET = 1800;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  command;
  logic [31:0] word;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] relocated;
  logic [1:0]  region;
  logic [9:0]  position;
  logic [2:0]  status;
  logic        last;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          pending;
  int          fail_count;

  logic        hold_long;
  logic        sender_calm;
  int unsigned items_sent;

  image_vector_got_relocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .command_i   (command),
    .word_i      (word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .relocated_o (relocated),
    .region_o    (region),
    .position_o  (position),
    .status_o    (status),
    .last_o      (last),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  relocation_checker u_relocation_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .command_i    (command),
    .word_i       (word),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .relocated_i  (relocated),
    .region_i     (region),
    .position_i   (position),
    .status_i     (status),
    .last_i       (last),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("** image_vector_got_relocator: FAILED **");
    $finish;
  end

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] w);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    word     <= w;
    do @(posedge clk); while (!in_ready);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic apply_layout(input cfg_t c);
    write_reg(REG_LOAD_BASE, c.load_base);
    write_reg(REG_IMAGE_BYTES, c.image_bytes);
    write_reg(REG_VECTOR_COUNT, 32'(c.vector_count));
    write_reg(REG_TABLE_OFFSET, c.table_offset);
    write_reg(REG_TABLE_BYTES, c.table_bytes);
    write_reg(REG_VECTOR_ROOM, 32'(c.vector_room));
    write_reg(REG_TABLE_ROOM, 32'(c.table_room));
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  function automatic logic [31:0] handler_word(input cfg_t c, input logic first);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (first || pick < 3) return $urandom;
    if (pick < 10) return '0;
    if (pick < 16) return ERASED_MARK;
    if (pick < 18) return $urandom_range(0, c.image_bytes - 1) & ~32'd1;
    if (pick < 19) return $urandom_range(c.image_bytes, 32'hFFFF_FFFF) | 32'd1;
    return $urandom_range(0, c.image_bytes - 1) | 32'd1;
  endfunction

  function automatic logic [31:0] table_word(input cfg_t c);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom_range(0, c.image_bytes - 1);
    if (pick < 7) return c.image_bytes - (pick - 5);
    return $urandom;
  endfunction

  task automatic make_layout(output cfg_t c, output logic sound);
    int unsigned vc, gw;
    vc = $urandom_range(2, 12);
    gw = $urandom_range(0, 12);
    c.load_base    = $urandom;
    c.table_offset = $urandom_range(0, 64) << 2;
    c.table_bytes  = gw << 2;
    c.image_bytes  = c.table_offset + c.table_bytes + $urandom_range(0, 4096);
    if (c.image_bytes < vc * 4) c.image_bytes = vc * 4;
    if ($urandom_range(0, 7) == 0) c.image_bytes = $urandom_range(c.image_bytes, 32'hFFFF_FFFF);
    c.vector_count = 9'(vc);
    c.vector_room  = 9'($urandom_range(vc, 256));
    c.table_room   = 11'($urandom_range(gw, 1024));
    sound = 1'b1;
    if ($urandom_range(0, 6) == 0) begin
      sound = 1'b0;
      case ($urandom_range(0, 8))
        0: c.image_bytes = $urandom_range(0, 7);
        1: c.vector_count = 9'($urandom_range(0, 1));
        2: c.vector_room = 9'(vc - 1);
        3: c.image_bytes = (vc - 1) * 4 + $urandom_range(0, 3);
        4: c.table_offset = c.table_offset | $urandom_range(1, 3);
        5: c.table_bytes = c.table_bytes | $urandom_range(1, 3);
        6: c.table_offset = c.image_bytes + 4 * $urandom_range(1, 8);
        7: c.table_bytes = ((c.image_bytes - c.table_offset) & ~32'd3) + 32'd4;
        default: c.table_bytes = (32'(c.table_room) + 32'd1) << 2;
      endcase
    end
  endtask

  task automatic run_job(input cfg_t c, input logic sound, input logic pause_mid);
    int unsigned vec_left, got_left, total;
    logic        first_vec;
    drain();
    apply_layout(c);
    sender_calm = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 5) == 0) send_item(2'($urandom_range(1, 3)), $urandom);
    send_item(CMD_START, $urandom);
    if (!sound) begin
      repeat ($urandom_range(1, 4)) send_item(2'($urandom_range(1, 3)), $urandom);
      return;
    end
    vec_left  = c.vector_count;
    got_left  = c.table_bytes >> 2;
    total     = vec_left + got_left;
    first_vec = 1'b1;
    while (vec_left + got_left > 0) begin
      if (got_left == 0 || (vec_left > 0 && $urandom_range(0, 1) == 1)) begin
        send_item(CMD_VECTOR, handler_word(c, first_vec));
        first_vec = 1'b0;
        vec_left--;
      end else begin
        send_item(CMD_GOT, table_word(c));
        got_left--;
      end
      if ($urandom_range(0, 99) == 0) send_item(CMD_START, $urandom);
      if (pause_mid && vec_left + got_left == total / 2) drain();
    end
    repeat ($urandom_range(0, 2)) send_item(2'($urandom_range(1, 3)), $urandom);
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned results_seen;
    logic        calm;
    results_seen = 0;
    calm         = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (results_seen % 64 == 0) calm = ($urandom_range(0, 3) == 0);
      if (hold_long) begin
        stall     = 400;
        hold_long = 1'b0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 18);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_seen++;
    end
  end

  initial begin : stimulus
    cfg_t c;
    logic sound;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    command     = CMD_START;
    word        = '0;
    out_ready   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_LOAD_BASE;
    cfg_wdata   = '0;
    hold_long   = 1'b0;
    sender_calm = 1'b0;
    items_sent  = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset leaves an empty layout, so the job is failed.
    send_item(CMD_START, 32'hFFFF_FFFF);
    send_item(CMD_VECTOR, 32'hFFFF_FFFF);
    send_item(CMD_GOT, 32'hFFFF_FFFF);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF);
    drain();
    apply_layout(cfg_t'{32'hFFFF_FFF0, 32'h100, 9'd4, 32'h40, 32'd8, 9'd4, 11'd2});
    send_item(CMD_START, '0);
    send_item(CMD_GOT, 32'h10);
    send_item(CMD_VECTOR, 32'hFFFF_FFFF);
    send_item(CMD_VECTOR, '0);
    send_item(CMD_VECTOR, ERASED_MARK);
    send_item(CMD_VECTOR, 32'hFF);
    send_item(CMD_GOT, 32'h100);
    send_item(CMD_VECTOR, 32'h1);
    send_item(CMD_GOT, 32'h1);
    send_item(CMD_START, '0);
    send_item(CMD_VECTOR, 32'h1234_5678);
    send_item(CMD_VECTOR, 32'h20);
    send_item(CMD_VECTOR, 32'h21);
    send_item(CMD_START, '0);
    send_item(CMD_VECTOR, '0);
    send_item(CMD_VECTOR, 32'h101);
    drain();
    apply_layout(cfg_t'{32'h0, 32'd8, 9'd2, 32'd8, 32'd0, 9'd2, 11'd0});
    send_item(CMD_START, '0);
    send_item(CMD_VECTOR, '0);
    send_item(CMD_VECTOR, 32'd7);
    send_item(CMD_GOT, 32'd3);

    items_sent = 0;
    run_job(cfg_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd256, 32'h0, 32'd16, 9'd256, 11'd4},
            1'b1, 1'b0);
    drain();
    hold_long = 1'b1;
    run_job(cfg_t'{32'h8000_0000, 32'hFFFF_FFFC, 9'd2, 32'hFFFF_EFFC, 32'd4096, 9'd2,
                   11'd1024}, 1'b1, 1'b1);
    while (items_sent < ITEM_TARGET) begin
      make_layout(c, sound);
      run_job(c, sound, $urandom_range(0, 7) == 0);
    end
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("** image_vector_got_relocator: PASSED **");
    end else begin
      $display("** image_vector_got_relocator: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ivgr_pkg.sv
rtl/ivgr_layout_chk.sv
rtl/image_vector_got_relocator.sv
dv/relocation_checker.sv
dv/tb_top.sv
